FILE: src/one_lane_direction_arbiter_assert.svh
// ----------------------------------------------------------------------------
// one lane direction arbiter assertion macros
// shorthand for clocked implication checks, reset disables them
// ----------------------------------------------------------------------------
`ifndef ONE_LANE_DIRECTION_ARBITER_ASSERT_SVH
`define ONE_LANE_DIRECTION_ARBITER_ASSERT_SVH

// same-cycle implication
`define OLDA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OLDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/olda_pkg.sv
// ----------------------------------------------------------------------------
// one lane direction arbiter package
// shared widths, codes and the records passed between the slot cells
// ----------------------------------------------------------------------------
package olda_pkg;

   // default number of slots
   localparam int OLDA_SLOTS = 16;

   // beat widths
   localparam int REQ_W  = 8;
   localparam int RSP_W  = 16;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   // register indexes (paddr bit 2 selects the register word)
   localparam logic REG_MAX_ON_BRIDGE = 1'b0;

   // reset capacity
   localparam logic [3:0] MAX_RESET = 4'd3;

   // event kinds
   localparam logic [1:0] ACT_ARRIVE = 2'd0;
   localparam logic [1:0] ACT_START  = 2'd1;
   localparam logic [1:0] ACT_EXIT   = 2'd2;

   // slot status codes
   localparam logic [1:0] ST_ABSENT  = 2'd0;
   localparam logic [1:0] ST_WAITING = 2'd1;
   localparam logic [1:0] ST_GOING   = 2'd2;
   localparam logic [1:0] ST_DONE    = 2'd3;

   // event broadcast to every cell
   typedef struct packed {
      logic       valid;
      logic [1:0] action;
      logic [3:0] slot_id;
      logic       heading;
   } evt_type;

   // scan record walking down the chain
   typedef struct packed {
      logic       valid;
      logic [3:0] count;
      logic       any_going;
      logic       dir;
      logic       found;
      logic [3:0] idx;
      logic       head;
   } scan_rec_type;

endpackage

FILE: src/one_lane_direction_arbiter.sv
// an event passes start_ff, each slot cell's rec_ff, hold_ff and rsp_data_ff
// no req beat is taken while a scan runs or a result sits in hold_ff; the
//   scan record walks one slot cell per cycle down the chain
// a finished result may wait on rsp while the next req beat is taken
// reset (synchronous): all slots absent, max_on_bridge 3, no grant held
// ----------------------------------------------------------------------------
// one lane direction arbiter
// grant to the lowest-index waiting slot for a shared one-direction resource
// ----------------------------------------------------------------------------
module one_lane_direction_arbiter #(
   parameter int SLOTS = olda_pkg::OLDA_SLOTS
) (
   input  logic                        clock,
   input  logic                        reset,
   // action [1:0], slot_id [5:2], heading [6]
   input  logic [olda_pkg::REQ_W-1:0]  req_tdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // grant_valid [0], grant_id [4:1], grant_changed [5], going_count [9:6]
   output logic [olda_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [olda_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [olda_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [olda_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import olda_pkg::*;

   logic             accept;
   evt_type          evt;
   scan_rec_type     chain [SLOTS+1];
   logic             start_ff;
   logic             busy_ff;
   logic [3:0]       max_ff;
   logic             gvalid_ff;
   logic             gvalid_in;
   logic [3:0]       gid_ff;
   logic [3:0]       gid_in;
   logic             changed;
   scan_rec_type     last;
   logic [RSP_W-1:0] hold_ff;
   logic             hold_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;
   logic             rsp_valid_ff;

   // request beat
   assign req_tready = !busy_ff && !hold_valid_ff;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      evt.valid   = accept;
      evt.action  = req_tdata[1:0];
      evt.slot_id = req_tdata[5:2];
      evt.heading = req_tdata[6];
   end

   // scan record entering the first cell
   always_comb begin
      chain[0].valid     = start_ff;
      chain[0].count     = 4'd0;
      chain[0].any_going = 1'b0;
      chain[0].dir       = 1'b0;
      chain[0].found     = 1'b0;
      chain[0].idx       = 4'd0;
      chain[0].head      = 1'b0;
   end

   // chain of slot cells
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      olda_cell #(
         .INDEX (i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .evt    (evt),
         .up_rec (chain[i]),
         .dn_rec (chain[i+1])
      );
   end

   assign last = chain[SLOTS];

   // grant decision at the end of the chain
   assign changed = (last.count < max_ff) && last.found
                    && (!last.any_going || (last.head == last.dir));
   assign gvalid_in = changed ? 1'b1 : gvalid_ff;
   assign gid_in    = changed ? last.idx : gid_ff;

   // control and grant state
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff      <= 1'b0;
         busy_ff       <= 1'b0;
         gvalid_ff     <= 1'b0;
         gid_ff        <= 4'd0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         start_ff <= accept;
         if (accept) begin
            busy_ff <= 1'b1;
         end
         if (last.valid) begin
            busy_ff       <= 1'b0;
            gvalid_ff     <= gvalid_in;
            gid_ff        <= gid_in;
            hold_valid_ff <= 1'b1;
         end else if (hold_valid_ff && (!rsp_valid_ff || rsp_tready)) begin
            hold_valid_ff <= 1'b0;
         end
         if (hold_valid_ff && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (last.valid) begin
         hold_ff <= {6'd0, last.count, changed, gid_in, gvalid_in};
      end
      if (hold_valid_ff && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= hold_ff;
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == REG_MAX_ON_BRIDGE) begin
         max_ff <= csr_pwdata[3:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_ON_BRIDGE)
                       ? {{(CSR_DW-4){1'b0}}, max_ff} : {CSR_DW{1'b0}};

endmodule

FILE: src/olda_cell.sv
// ----------------------------------------------------------------------------
// one lane direction arbiter slot cell
// holds one slot's status and heading, folds it into the passing scan record
// ----------------------------------------------------------------------------
module olda_cell #(
   parameter int INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  olda_pkg::evt_type      evt,
   input  olda_pkg::scan_rec_type up_rec,
   output olda_pkg::scan_rec_type dn_rec
);
   import olda_pkg::*;

   logic [1:0]   status_ff;
   logic [1:0]   status_in;
   logic         heading_ff;
   logic         heading_in;
   logic         hit;
   scan_rec_type rec_ff;
   scan_rec_type rec_in;

   // event addressed to this slot
   assign hit = evt.valid && (32'(evt.slot_id) == INDEX);

   // status update
   always_comb begin
      status_in  = status_ff;
      heading_in = heading_ff;
      if (hit) begin
         unique case (evt.action)
            ACT_ARRIVE: begin
               status_in  = ST_WAITING;
               heading_in = evt.heading;
            end
            ACT_START: status_in = ST_GOING;
            ACT_EXIT:  status_in = ST_DONE;
            default:   status_in = status_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ST_ABSENT;
      end else begin
         status_ff <= status_in;
      end
   end

   // heading has no reset value
   always_ff @(posedge clock) begin
      heading_ff <= heading_in;
   end

   // fold this slot into the scan record
   always_comb begin
      rec_in = up_rec;
      if (status_ff == ST_GOING) begin
         rec_in.count     = (up_rec.count == 4'hF) ? up_rec.count : up_rec.count + 4'd1;
         rec_in.any_going = 1'b1;
         rec_in.dir       = heading_ff;
      end
      if (status_ff == ST_WAITING && !up_rec.found) begin
         rec_in.found = 1'b1;
         rec_in.idx   = 4'(INDEX);
         rec_in.head  = heading_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.valid <= 1'b0;
      end else begin
         rec_ff <= rec_in;
      end
   end

   assign dn_rec = rec_ff;

endmodule

FILE: src/olda_checker.sv
// ----------------------------------------------------------------------------
// one lane direction arbiter port checker
// watches the top level ports for ordering and result consistency
// ----------------------------------------------------------------------------
`include "one_lane_direction_arbiter_assert.svh"

module olda_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [olda_pkg::RSP_W-1:0]  rsp_tdata,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready
);

   // a stalled result beat holds
   `OLDA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "rsp beat dropped or changed while stalled")

   // a new grant implies a grant is held
   `OLDA_ASSERT_NOW(a_grant_held, clock, reset, rsp_tvalid && rsp_tdata[5],
      rsp_tdata[0], "grant_changed without grant_valid")

   // one event at a time: the scan blocks the next req beat
   `OLDA_ASSERT_NEXT(a_one_event, clock, reset, req_tvalid && req_tready,
      !req_tready, "req taken during a running scan")

   // once a grant is seen it stays valid
   `OLDA_ASSERT_NEXT(a_grant_sticky, clock, reset, rsp_tvalid && rsp_tdata[0],
      !rsp_tvalid || rsp_tdata[0], "grant_valid fell after a grant")

endmodule

bind one_lane_direction_arbiter olda_checker u_olda_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .rsp_tdata   (rsp_tdata),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready)
);

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// one lane direction arbiter testbench
// drives slot events on the req stream, predicts the grant status that each
// event must return and checks every rsp beat field by field; runs directed
// events, random traffic under several capacities and idling mixes, the zero
// capacity case and a fully loaded bridge
// ----------------------------------------------------------------------------
module testbench;
   import olda_pkg::*;

   localparam int SLOTS = OLDA_SLOTS;

   // the one action code the block leaves unused
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // byte address of the capacity register
   localparam logic [CSR_AW-1:0] CAPACITY_ADDR = {REG_MAX_ON_BRIDGE, 2'b00};

   typedef struct packed {
      logic       grant_valid;
      logic [3:0] grant_id;
      logic       grant_changed;
      logic [3:0] going_count;
   } grant_status_type;

   logic              clock;
   logic              reset       = 1'b1;
   logic [REQ_W-1:0]  req_tdata   = '0;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // predicted block state
   logic [1:0] lane_status [SLOTS];
   logic       lane_heading [SLOTS];
   logic [3:0] holder_id;
   logic       holder_valid;
   logic [3:0] bridge_capacity;
   grant_status_type expected_grants [$];

   // stimulus side view of the slots, used only to shape traffic
   logic [1:0] plan_status [SLOTS];
   logic       plan_seen [SLOTS];
   logic       plan_heading;

   int fail_count;
   int sender_idle_pct;
   int receiver_stall_pct;

   one_lane_direction_arbiter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // generous run limit
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   // apply one event to the predicted state and work out its grant status
   function automatic grant_status_type predict_grant(input logic [1:0] act,
                                                      input logic [3:0] slot,
                                                      input logic       hd);
      grant_status_type status;
      int   going;
      int   i;
      logic any_going;
      logic active_dir;
      logic changed;
      logic searching;

      case (act)
         ACT_ARRIVE: begin
            lane_status[slot]  = ST_WAITING;
            lane_heading[slot] = hd;
         end
         ACT_START: lane_status[slot] = ST_GOING;
         ACT_EXIT:  lane_status[slot] = ST_DONE;
         default: ;
      endcase

      // the highest going slot sets the direction of travel
      going      = 0;
      any_going  = 1'b0;
      active_dir = 1'b0;
      for (i = 0; i < SLOTS; i++) begin
         if (lane_status[i] == ST_GOING) begin
            going++;
            any_going  = 1'b1;
            active_dir = lane_heading[i];
         end
      end

      // first waiting slot wins or blocks everyone behind it
      changed   = 1'b0;
      searching = (going < bridge_capacity);
      for (i = 0; i < SLOTS; i++) begin
         if (searching && lane_status[i] == ST_WAITING) begin
            searching = 1'b0;
            if (!any_going || lane_heading[i] == active_dir) begin
               changed      = 1'b1;
               holder_id    = i[3:0];
               holder_valid = 1'b1;
            end
         end
      end

      status.grant_valid   = holder_valid;
      status.grant_id      = holder_id;
      status.grant_changed = changed;
      status.going_count   = (going > 15) ? 4'd15 : going[3:0];
      return status;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // receiver ready, stalling at the current rate
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // check result beats, then record the grant status of each taken event
   always @(posedge clock) begin : track_beats
      grant_status_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_grants.size() == 0) begin
               $error("result beat %h arrived with no event outstanding", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_grants.pop_front();
               check_field("grant_valid", want.grant_valid, rsp_tdata[0]);
               check_field("grant_id", want.grant_id, rsp_tdata[4:1]);
               check_field("grant_changed", want.grant_changed, rsp_tdata[5]);
               check_field("going_count", want.going_count, rsp_tdata[9:6]);
            end
         end
         if (req_tvalid && req_tready)
            expected_grants.push_back(predict_grant(req_tdata[1:0], req_tdata[5:2],
                                                    req_tdata[6]));
      end
   end

   // one event beat; valid stays high after the beat unless a gap follows
   task automatic send_event(input logic [1:0] act, input logic [3:0] slot,
                             input logic hd);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_tdata  <= {1'b0, hd, slot, act};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_read(output logic [CSR_DW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CAPACITY_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // write the capacity while idle, then read it back
   task automatic set_capacity(input logic [3:0] cap);
      logic [CSR_DW-1:0] readback;
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAPACITY_ADDR;
      csr_pwdata  <= {{(CSR_DW-4){1'b0}}, cap};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      bridge_capacity = cap;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_read(readback);
      check_field("max_on_bridge", cap, readback);
   endtask

   // mostly orderly arrive, start and exit traffic with some noise mixed in
   task automatic send_random_event();
      int         i;
      int unsigned pick;
      int         free_q [$];
      int         wait_q [$];
      int         go_q [$];
      logic [1:0] act;
      logic [3:0] slot;
      logic       hd;

      for (i = 0; i < SLOTS; i++) begin
         case (plan_status[i])
            ST_WAITING: wait_q.push_back(i);
            ST_GOING:   go_q.push_back(i);
            default:    free_q.push_back(i);
         endcase
      end

      pick = $urandom_range(99);
      hd   = ($urandom_range(99) < 70) ? plan_heading : ~plan_heading;
      act  = ACT_ARRIVE;
      if (free_q.size() == 0)
         slot = 4'($urandom_range(SLOTS-1));
      else if ($urandom_range(1) == 0)
         slot = 4'(free_q[0]);
      else
         slot = 4'(free_q[$urandom_range(free_q.size()-1)]);

      if (pick < 10) begin
         act  = 2'($urandom_range(3));
         slot = 4'($urandom_range(SLOTS-1));
         hd   = 1'($urandom_range(1));
         // a slot must have arrived once before it may start
         if (act == ACT_START && !plan_seen[slot])
            act = ACT_ARRIVE;
      end else if (pick >= 45 && pick < 75 && wait_q.size() != 0) begin
         act  = ACT_START;
         slot = ($urandom_range(99) < 70) ? 4'(wait_q[0])
                                          : 4'(wait_q[$urandom_range(wait_q.size()-1)]);
      end else if (pick >= 75 && go_q.size() != 0) begin
         act  = ACT_EXIT;
         slot = 4'(go_q[$urandom_range(go_q.size()-1)]);
      end

      case (act)
         ACT_ARRIVE: begin
            plan_status[slot] = ST_WAITING;
            plan_seen[slot]   = 1'b1;
            plan_heading      = hd;
         end
         ACT_START: plan_status[slot] = ST_GOING;
         ACT_EXIT:  plan_status[slot] = ST_DONE;
         default: ;
      endcase
      send_event(act, slot, hd);
   endtask

   // reset capacity, every action, blocking by the other heading, re-grant
   task automatic test_directed_events();
      logic [CSR_DW-1:0] readback;
      csr_read(readback);
      check_field("max_on_bridge", MAX_RESET, readback);
      send_event(ACT_EXIT, 4'd0, 1'b0);
      send_event(ACT_UNUSED, 4'd15, 1'b1);
      send_event(ACT_ARRIVE, 4'd0, 1'b0);
      send_event(ACT_ARRIVE, 4'd1, 1'b1);
      send_event(ACT_START, 4'd0, 1'b0);
      send_event(ACT_ARRIVE, 4'd2, 1'b0);
      send_event(ACT_EXIT, 4'd0, 1'b1);
      send_event(ACT_START, 4'd1, 1'b0);
      send_event(ACT_ARRIVE, 4'd15, 1'b1);
      send_event(ACT_EXIT, 4'd1, 1'b0);
      send_event(ACT_START, 4'd2, 1'b1);
      send_event(ACT_EXIT, 4'd2, 1'b0);
      send_event(ACT_ARRIVE, 4'd3, 1'b1);
      send_event(ACT_ARRIVE, 4'd4, 1'b1);
      send_event(ACT_ARRIVE, 4'd5, 1'b1);
      send_event(ACT_START, 4'd15, 1'b0);
      send_event(ACT_START, 4'd3, 1'b0);
      send_event(ACT_START, 4'd4, 1'b0);
      send_event(ACT_START, 4'd5, 1'b1);
      send_event(ACT_UNUSED, 4'd10, 1'b0);
      send_event(ACT_EXIT, 4'd15, 1'b1);
      send_event(ACT_EXIT, 4'd3, 1'b0);
      send_event(ACT_EXIT, 4'd4, 1'b0);
      send_event(ACT_EXIT, 4'd5, 1'b0);
      for (int i = 0; i < SLOTS; i++) begin
         plan_status[i] = lane_status[i];
         plan_seen[i]   = (i <= 5 || i == 15);
      end
   endtask

   task automatic test_random_traffic(input logic [3:0] cap, input int idle_pct,
                                      input int stall_pct, input int count);
      set_capacity(cap);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) send_random_event();
   endtask

   // with no capacity at all nothing may be granted
   task automatic test_zero_capacity();
      set_capacity(4'd0);
      sender_idle_pct    = 30;
      receiver_stall_pct = 30;
      repeat (30) send_random_event();
   endtask

   // every slot going at once, count reaching and holding at its top
   task automatic test_full_bridge();
      int i;
      set_capacity(4'd15);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      for (i = 0; i < SLOTS; i++)
         if (!plan_seen[i]) begin
            send_event(ACT_ARRIVE, i[3:0], i[0]);
            plan_seen[i] = 1'b1;
         end
      for (i = 0; i < SLOTS; i++)
         send_event(ACT_START, i[3:0], 1'b0);
      send_event(ACT_ARRIVE, 4'd7, 1'b1);
      for (i = SLOTS-1; i >= 0; i--)
         send_event(ACT_EXIT, i[3:0], 1'b0);
   endtask

   initial begin
      fail_count         = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      bridge_capacity    = MAX_RESET;
      holder_id          = 4'd0;
      holder_valid       = 1'b0;
      plan_heading       = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         lane_status[i]  = ST_ABSENT;
         lane_heading[i] = 1'b0;
         plan_status[i]  = ST_ABSENT;
         plan_seen[i]    = 1'b0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_events();
      test_random_traffic(4'd2, 0, 0, 265);
      test_random_traffic(4'd1, 87, 0, 265);
      test_random_traffic(4'd15, 0, 87, 265);
      test_random_traffic(4'd4, 30, 30, 265);
      test_zero_capacity();
      test_full_bridge();

      // drain and let the last scan settle
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (SLOTS + 8) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
